// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: design/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// types and constants for the rgb to hsl converter
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

    localparam int COMP_W   = 8;
    localparam int HUE_W    = 9;
    localparam int WORK_W   = 2 * COMP_W;
    localparam int DIV_STEPS = COMP_W;

    localparam logic [HUE_W-1:0] HUE_OFS_RED   = 9'd0;
    localparam logic [HUE_W-1:0] HUE_OFS_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_OFS_BLUE  = 9'd240;
    localparam logic [HUE_W:0]   HUE_WRAP      = 10'd360;
    localparam logic [COMP_W:0]  SUM_FULL      = 9'd510;
    localparam logic [COMP_W:0]  SUM_HALF      = 9'd255;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [COMP_W-1:0] saturation;
        logic [COMP_W-1:0] lightness;
    } hsl_t;

    // divider work words carry {remainder, dividend bits / quotient bits}
    typedef struct packed {
        logic [WORK_W-1:0] sat_work;
        logic [COMP_W-1:0] sat_den;
        logic [WORK_W-1:0] hue_work;
        logic [COMP_W-1:0] hue_den;
        logic [HUE_W-1:0]  hue_ofs;
        logic              hue_neg;
        logic              grey;
        logic [COMP_W-1:0] light;
    } lane_t;

endpackage

// File: design/rgbhsl_prep.sv
// ----------------------------------------------------------------------------
// rgbhsl_prep
// front stage: max, min, lightness, divider operands
// ----------------------------------------------------------------------------
module rgbhsl_prep (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rgbhsl_pkg::pixel_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rgbhsl_pkg::lane_t    out_data
);
    import rgbhsl_pkg::*;

    logic              valid_reg;
    lane_t             data_reg;
    lane_t             data_next;
    logic [COMP_W-1:0] mx;
    logic [COMP_W-1:0] mn;
    logic [COMP_W-1:0] first;
    logic [COMP_W-1:0] second;
    logic [COMP_W-1:0] diff;
    logic [COMP_W-1:0] delta;
    logic [COMP_W:0]   sum;
    logic [COMP_W:0]   sum_rev;
    logic [HUE_W-1:0]  ofs;

    always_comb begin
        mx = in_data.red;
        mn = in_data.red;
        if (in_data.green > mx) mx = in_data.green;
        if (in_data.blue > mx) mx = in_data.blue;
        if (in_data.green < mn) mn = in_data.green;
        if (in_data.blue < mn) mn = in_data.blue;

        if (mx == in_data.red) begin
            ofs = HUE_OFS_RED;
            first = in_data.green;
            second = in_data.blue;
        end else if (mx == in_data.green) begin
            ofs = HUE_OFS_GREEN;
            first = in_data.blue;
            second = in_data.red;
        end else begin
            ofs = HUE_OFS_BLUE;
            first = in_data.red;
            second = in_data.green;
        end

        diff = (first >= second) ? (first - second) : (second - first);
        delta = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        sum_rev = SUM_FULL - sum;

        data_next.sat_work = {delta, {COMP_W{1'b0}}} - {{COMP_W{1'b0}}, delta};
        data_next.sat_den  = (sum < SUM_HALF) ? sum[COMP_W-1:0] : sum_rev[COMP_W-1:0];
        // 60 * diff as 64 * diff - 4 * diff
        data_next.hue_work = {2'b00, diff, 6'b0} - {6'b0, diff, 2'b0};
        data_next.hue_den  = delta;
        data_next.hue_ofs  = ofs;
        data_next.hue_neg  = (first < second);
        data_next.grey     = (mx == mn);
        data_next.light    = sum[COMP_W:1];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/rgbhsl_div_cell.sv
// ----------------------------------------------------------------------------
// rgbhsl_div_cell
// one restoring division step for saturation and hue, registered
// ----------------------------------------------------------------------------
module rgbhsl_div_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rgbhsl_pkg::lane_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rgbhsl_pkg::lane_t    out_data
);
    import rgbhsl_pkg::*;

    logic  valid_reg;
    lane_t data_reg;
    lane_t data_next;

    function automatic logic [WORK_W-1:0] div_step(
        input logic [WORK_W-1:0] work,
        input logic [COMP_W-1:0] den
    );
        logic [WORK_W:0]  t;
        logic [COMP_W:0]  hi;
        logic             q;
        t = {work, 1'b0};
        hi = t[WORK_W:COMP_W];
        q = (hi >= {1'b0, den});
        if (q) hi = hi - {1'b0, den};
        return {hi[COMP_W-1:0], t[COMP_W-1:1], q};
    endfunction

    always_comb begin
        data_next = in_data;
        data_next.sat_work = div_step(in_data.sat_work, in_data.sat_den);
        data_next.hue_work = div_step(in_data.hue_work, in_data.hue_den);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/rgbhsl_finish.sv
// ----------------------------------------------------------------------------
// rgbhsl_finish
// hue assembly and output register
// ----------------------------------------------------------------------------
module rgbhsl_finish (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rgbhsl_pkg::lane_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rgbhsl_pkg::hsl_t     out_data
);
    import rgbhsl_pkg::*;

    logic              valid_reg;
    hsl_t              data_reg;
    hsl_t              data_next;
    logic [COMP_W-1:0] mag;
    logic [HUE_W:0]    hue_sum;
    logic [HUE_W:0]    hue_wrapped;

    always_comb begin
        mag = in_data.hue_work[COMP_W-1:0];
        if (in_data.hue_neg) begin
            hue_sum = {1'b0, in_data.hue_ofs} - {2'b00, mag};
        end else begin
            hue_sum = {1'b0, in_data.hue_ofs} + {2'b00, mag};
        end
        hue_wrapped = hue_sum[HUE_W] ? (hue_sum + HUE_WRAP) : hue_sum;

        data_next.lightness = in_data.light;
        if (in_data.grey) begin
            data_next.hue        = '0;
            data_next.saturation = '0;
        end else begin
            data_next.hue        = hue_wrapped[HUE_W-1:0];
            data_next.saturation = in_data.sat_work[COMP_W-1:0];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// 8-bit rgb pixel to integer hsl, pipelined
// ----------------------------------------------------------------------------
// s_valid/s_ready/s_data carry one rgb pixel per request; m_valid/m_ready/
// m_data carry the matching hue (degrees), saturation and lightness.
// results leave in the order the pixels arrived, one per pixel.
// a request passes the front stage, eight division cells (one quotient bit
// each) and the output stage, each registered, on its way to m_valid.
// throughput: one pixel per clock while m_ready is high.
// every stage holds its own valid bit and fills when the next one is empty or
// moving, so a stalled receiver lets bubbles close up and s_ready stays high
// until all ten stages hold a pixel.
// reset (aresetn low, synchronous) empties every stage; no results are
// pending afterwards.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_hsl_converter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rgbhsl_pkg::pixel_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rgbhsl_pkg::hsl_t     m_data
);
    import rgbhsl_pkg::*;

    lane_t lane      [0:DIV_STEPS];
    logic  lane_vld  [0:DIV_STEPS];
    logic  lane_rdy  [0:DIV_STEPS];
    logic  prep_rdy;
    logic  fin_rdy;

    rgbhsl_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (prep_rdy),
        .in_data   (s_data),
        .out_valid (lane_vld[0]),
        .out_ready (lane_rdy[0]),
        .out_data  (lane[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        rgbhsl_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lane_vld[i]),
            .in_ready  (lane_rdy[i]),
            .in_data   (lane[i]),
            .out_valid (lane_vld[i+1]),
            .out_ready (lane_rdy[i+1]),
            .out_data  (lane[i+1])
        );
    end

    rgbhsl_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lane_vld[DIV_STEPS]),
        .in_ready  (fin_rdy),
        .in_data   (lane[DIV_STEPS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    assign lane_rdy[DIV_STEPS] = fin_rdy;
    assign s_ready = prep_rdy;

    logic last_stall;
    assign last_stall = lane_vld[DIV_STEPS] && !fin_rdy;

    `ASSERT_ALWAYS(a_hue_range, aclk, aresetn, !m_valid || (m_data.hue < 9'd360))
    `ASSERT_IMPLIES(a_full_when_blocked, aclk, aresetn, !s_ready, m_valid && lane_vld[0] && lane_vld[DIV_STEPS])
    `ASSERT_NEXT(a_cell_hold, aclk, aresetn, last_stall, lane_vld[DIV_STEPS] && $stable(lane[DIV_STEPS]))

endmodule
